### rtl/cic_pkg.sv
// Shared types and constants for the call id ring cache.
`default_nettype none

package cic_pkg;

    localparam int DEFAULT_ENTRIES = 16;
    localparam int WORD_W          = 32;
    localparam int SLOT_OUT_W      = 4;
    localparam int IN_DATA_W       = 160;
    localparam int OUT_DATA_W      = 136;

    typedef enum logic
    {
        REQ_STORE  = 1'b0,
        REQ_LOOKUP = 1'b1
    } req_kind_t;

    // Controller to datapath
    typedef struct packed
    {
        logic start;     // capture request, arm search at write pointer
        logic scan;      // issue one table read and compare the previous one
        logic write;     // write the record into the resolved slot
        logic read;      // read the resolved slot back
        logic load_out;  // load the output register
    } cic_cmd_t;

    // Datapath to controller
    typedef struct packed
    {
        logic match;     // compared slot holds the key
        logic miss;      // last slot compared without a match
        logic is_store;  // captured request is a store
        logic out_free;  // output register can take a new result
    } cic_status_t;

endpackage

`default_nettype wire

### rtl/cic_datapath.sv
// Datapath: record tables, search pipeline, write pointer and result register.
`default_nettype none

module cic_datapath
    import cic_pkg::*;
#(
    parameter int ENTRIES = DEFAULT_ENTRIES
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cic_cmd_t                cmd,
    output cic_status_t                  st,
    input  wire logic                    in_type,
    input  wire logic [IN_DATA_W-1:0]    in_data,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic                         out_found,
    output logic [OUT_DATA_W-1:0]        out_data
);

    localparam int SW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    // Captured request
    logic              req_reg;
    logic [WORD_W-1:0] key_reg;
    logic [WORD_W-1:0] frame_reg;
    logic [WORD_W-1:0] prog_reg;
    logic [WORD_W-1:0] vers_reg;
    logic [WORD_W-1:0] proc_reg;

    // Tables
    logic [WORD_W-1:0] id_mem    [ENTRIES];
    logic [WORD_W-1:0] frame_mem [ENTRIES];
    logic [WORD_W-1:0] prog_mem  [ENTRIES];
    logic [WORD_W-1:0] vers_mem  [ENTRIES];
    logic [WORD_W-1:0] proc_mem  [ENTRIES];
    logic              valid_reg [ENTRIES];

    logic [SW-1:0]     wp_reg;
    logic [SW-1:0]     scan_ptr_reg;
    logic [CW-1:0]     issued_reg;
    logic              live_reg;
    logic [WORD_W-1:0] cmp_id_reg;
    logic              cmp_valid_reg;
    logic [SW-1:0]     cmp_slot_reg;

    logic              hit_reg;
    logic [SW-1:0]     slot_reg;
    logic              slot_valid_reg;

    logic [WORD_W-1:0] rd_frame_reg;
    logic [WORD_W-1:0] rd_prog_reg;
    logic [WORD_W-1:0] rd_vers_reg;
    logic [WORD_W-1:0] rd_proc_reg;
    logic              rd_valid_reg;

    logic              out_valid_reg;
    logic              out_found_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [WORD_W-1:0] cmp_eff_id;
    logic              match;
    logic              miss;
    logic              issue;
    logic [SW-1:0]     scan_ptr_next;
    logic [SW-1:0]     wp_next;
    logic              frame_wr;
    logic [WORD_W-1:0] frame_wr_data;
    logic              show;
    logic [OUT_DATA_W-1:0] out_data_next;

    assign cmp_eff_id    = cmp_valid_reg ? cmp_id_reg : '0;
    assign match         = live_reg && (cmp_eff_id == key_reg);
    assign miss          = live_reg && !match && (issued_reg == CW'(ENTRIES));
    assign issue         = cmd.scan && (issued_reg != CW'(ENTRIES));
    assign scan_ptr_next = (scan_ptr_reg == '0) ? SW'(ENTRIES - 1) : scan_ptr_reg - 1'b1;
    assign wp_next       = (wp_reg == SW'(ENTRIES - 1)) ? '0 : wp_reg + 1'b1;

    // Frame is written when a slot is newly taken, or cleared when a store
    // hits a slot that was never written (id zero).
    assign frame_wr      = !hit_reg || !slot_valid_reg;
    assign frame_wr_data = hit_reg ? '0 : frame_reg;

    assign show = (req_reg == REQ_STORE) || hit_reg;

    always_comb
    begin
        out_data_next = '0;
        if (show)
        begin
            out_data_next[SLOT_OUT_W-1:0] = SLOT_OUT_W'(slot_reg);
            if (rd_valid_reg)
            begin
                out_data_next[SLOT_OUT_W +: WORD_W]              = rd_prog_reg;
                out_data_next[SLOT_OUT_W + WORD_W +: WORD_W]     = rd_vers_reg;
                out_data_next[SLOT_OUT_W + 2 * WORD_W +: WORD_W] = rd_proc_reg;
                out_data_next[SLOT_OUT_W + 3 * WORD_W +: WORD_W] = rd_frame_reg;
            end
        end
    end

    assign st.match    = match;
    assign st.miss     = miss;
    assign st.is_store = (req_reg == REQ_STORE);
    assign st.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_found = out_found_reg;
    assign out_data  = out_data_reg;

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            req_reg   <= in_type;
            key_reg   <= in_data[0 +: WORD_W];
            frame_reg <= in_data[WORD_W +: WORD_W];
            prog_reg  <= in_data[2 * WORD_W +: WORD_W];
            vers_reg  <= in_data[3 * WORD_W +: WORD_W];
            proc_reg  <= in_data[4 * WORD_W +: WORD_W];
        end
        if (issue)
        begin
            cmp_id_reg    <= id_mem[scan_ptr_reg];
            cmp_valid_reg <= valid_reg[scan_ptr_reg];
            cmp_slot_reg  <= scan_ptr_reg;
        end
        if (cmd.scan && (match || miss))
        begin
            slot_reg       <= match ? cmp_slot_reg : wp_reg;
            slot_valid_reg <= match && cmp_valid_reg;
        end
        if (cmd.read)
        begin
            rd_frame_reg <= frame_mem[slot_reg];
            rd_prog_reg  <= prog_mem[slot_reg];
            rd_vers_reg  <= vers_mem[slot_reg];
            rd_proc_reg  <= proc_mem[slot_reg];
            rd_valid_reg <= valid_reg[slot_reg];
        end
        if (cmd.load_out)
        begin
            out_found_reg <= hit_reg;
            out_data_reg  <= out_data_next;
        end
    end

    // Table writes
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            id_mem[slot_reg]   <= key_reg;
            prog_mem[slot_reg] <= prog_reg;
            vers_mem[slot_reg] <= vers_reg;
            proc_mem[slot_reg] <= proc_reg;
            if (frame_wr)
            begin
                frame_mem[slot_reg] <= frame_wr_data;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            wp_reg        <= '0;
            scan_ptr_reg  <= '0;
            issued_reg    <= '0;
            live_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                scan_ptr_reg <= wp_reg;
                issued_reg   <= '0;
                live_reg     <= 1'b0;
            end
            else if (cmd.scan)
            begin
                live_reg <= issue;
                if (issue)
                begin
                    scan_ptr_reg <= scan_ptr_next;
                    issued_reg   <= issued_reg + 1'b1;
                end
                if (match || miss)
                begin
                    hit_reg <= match;
                end
            end
            if (cmd.write)
            begin
                valid_reg[slot_reg] <= 1'b1;
                if (!hit_reg)
                begin
                    wp_reg <= wp_next;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= SW'(ENTRIES - 1))
        else $error("write pointer beyond table");

    a_match_miss_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(match && miss))
        else $error("search reported hit and miss together");

    a_wp_moves_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(wp_reg) |-> $past(cmd.write && !hit_reg))
        else $error("write pointer moved without a slot being taken");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("output overwritten before transfer");
`endif

endmodule

`default_nettype wire

### rtl/cic_controller.sv
// Controller: sequences search, write, read-back and result load per request.
`default_nettype none

module cic_controller
    import cic_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire cic_status_t st,
    output cic_cmd_t         cmd
);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SEARCH,
        S_WRITE,
        S_READ,
        S_FILL
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
                if (in_valid)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                cmd.scan = 1'b1;
                if (st.match || st.miss)
                begin
                    state_next = st.is_store ? S_WRITE : S_READ;
                end
            end
            S_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_FILL;
            end
            S_FILL:
            begin
                cmd.load_out = st.out_free;
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/call_id_ring_cache.sv
// Top level of the call id ring cache: stream ports, controller and datapath.
`default_nettype none

//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata: call_id, frame_no, prog_num,
//                                                    vers_num, proc_num; tuser: req_type
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: slot_index, found_prog,
//                                                    found_vers, found_proc, found_frame;
//                                                    tuser: found
//
//  Each request runs from transfer to result load before the next is taken,
//  and the next transfer can come in the cycle after the load at the earliest:
//  the search reads one table slot per cycle through a registered read port,
//  so each slot read sits in the compare registers before it meets the key.
//  A store then writes the record, and every request reads its slot back
//  and loads the result.
//  Reset clears the write pointer and the per-slot valid bits at once; no sweep.
//  A result waiting on m_axis holds the controller in its final step only;
//  the next request is taken as soon as the result sits in the output register.

module call_id_ring_cache
    import cic_pkg::*;
#(
    parameter int ENTRIES = DEFAULT_ENTRIES
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [31:0] call_id, [63:32] frame_no, [95:64] prog_num,
    // [127:96] vers_num, [159:128] proc_num
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] req_type
    input  wire logic                  s_axis_tuser,

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [3:0] slot_index, [35:4] found_prog, [67:36] found_vers,
    // [99:68] found_proc, [131:100] found_frame, [135:132] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // [0] found
    output logic                       m_axis_tuser
);

    cic_cmd_t    cmd;
    cic_status_t st;

    // Sequence each request: search, optional write, read back, load result
    cic_controller u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // Hold the tables, the write pointer and the output register
    cic_datapath #(
        .ENTRIES (ENTRIES)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_type   (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_found (m_axis_tuser),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire
